// ----- rtl/tdlc_pkg.sv -----
// ----------------------------------------------------------------------------
// tdlc_pkg
// Shared types, constants and helpers of the transaction dirty-line counter.
// ----------------------------------------------------------------------------
package tdlc_pkg;

   localparam int SET_CAPACITY = 256;
   localparam int ADDRESS_BITS = 48;
   localparam int IDX_W        = $clog2(SET_CAPACITY);
   localparam int FILL_W       = IDX_W + 1;
   localparam int LEN_W        = 9;
   localparam int CNT_W        = 32;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int REG_IDX_W    = CSR_ADDR_W - 2;

   localparam logic [LEN_W-1:0]     LEN_RESET             = LEN_W'(256);
   localparam logic [REG_IDX_W-1:0] REG_TRANSACTION_LENGTH = REG_IDX_W'(0);

   typedef struct packed {
      logic                    kind;
      logic [ADDRESS_BITS-1:0] line_address;
   } tdlc_req_type;

   typedef struct packed {
      logic [CNT_W-1:0] transaction_index;
      logic [CNT_W-1:0] flush_count;
      logic [CNT_W-1:0] read_count;
      logic [CNT_W-1:0] write_count;
      logic             newly_dirtied;
      logic             set_full;
   } tdlc_rsp_type;

   // queue entry: access plus the front's boundary decision
   typedef struct packed {
      logic                    new_txn;
      logic                    kind;
      logic [ADDRESS_BITS-1:0] line_address;
   } tdlc_qent_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
   endfunction

endpackage

// ----- rtl/transaction_dirty_line_counter_unit.sv -----
// ----------------------------------------------------------------------------
// transaction_dirty_line_counter_unit
// Counts reads, writes, transactions and newly dirtied lines over a trace.
// ----------------------------------------------------------------------------
//
// Channel   | Handshake                      | Payload
// ----------+--------------------------------+-------------------------------
// request   | start, busy (taken: start&~busy)| req_data  (kind, line_address)
// response  | rsp_valid, one-cycle strobe    | rsp_data  (counts and flags)
// registers | psel/penable/pwrite, pready=1  | paddr, pwdata, prdata
//
// The back end finishes a read at once; a write compares the lines currently
// in the dirty set (at most 256) one entry per cycle, since the set sits in a
// memory with one write port and one registered read port.
// The front end and a two-entry queue take items while the back end works;
// busy rises only when the queue is full.
// Reset is synchronous and leaves the set empty, all counts at zero and the
// transaction length at 256. No clearing pass is needed: the fill count
// bounds every search. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module transaction_dirty_line_counter_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              start,
   output logic                              busy,
   input  tdlc_pkg::tdlc_req_type            req_data,
   // response channel
   output logic                              rsp_valid,
   output tdlc_pkg::tdlc_rsp_type            rsp_data,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [tdlc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [tdlc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [tdlc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import tdlc_pkg::*;

   logic [LEN_W-1:0]     len_ff, len_in;
   logic                 csr_wr;
   logic [REG_IDX_W-1:0] reg_idx;

   logic          q_full;
   logic          q_empty;
   logic          push;
   logic          pop;
   tdlc_qent_type push_data;
   tdlc_qent_type q_head;

   // register file: only the transaction length lives here
   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign csr_wr  = psel & penable & pwrite & pready;

   always_comb begin
      len_in = len_ff;
      if (csr_wr && (reg_idx == REG_TRANSACTION_LENGTH)) begin
         len_in = pwdata[LEN_W-1:0];
      end
      prdata = '0;
      if (reg_idx == REG_TRANSACTION_LENGTH) begin
         prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, len_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_RESET;
      end else begin
         len_ff <= len_in;
      end
   end

   // front: takes items, marks transaction boundaries
   tdlc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .txn_len   (len_ff),
      .q_full    (q_full),
      .busy      (busy),
      .push      (push),
      .push_data (push_data)
   );

   // decoupling queue
   tdlc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   // back: set search, counters and result register
   tdlc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/tdlc_front.sv -----
// ----------------------------------------------------------------------------
// tdlc_front
// Accepts items, tracks the position in the transaction and tags boundaries.
// ----------------------------------------------------------------------------
module tdlc_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  tdlc_pkg::tdlc_req_type         req_data,
   input  logic [tdlc_pkg::LEN_W-1:0]     txn_len,
   input  logic                           q_full,
   output logic                           busy,
   output logic                           push,
   output tdlc_pkg::tdlc_qent_type        push_data
);
   import tdlc_pkg::*;

   logic [LEN_W-1:0] pos_ff;
   logic [LEN_W-1:0] pos_in;
   logic [LEN_W-1:0] len_eff;
   logic             boundary;

   // zero length behaves as one
   assign len_eff  = (txn_len == '0) ? LEN_W'(1) : txn_len;
   assign boundary = (pos_ff >= len_eff);
   assign busy     = q_full;
   assign push     = start & ~q_full;

   always_comb begin
      push_data.new_txn      = boundary;
      push_data.kind         = req_data.kind;
      push_data.line_address = req_data.line_address;
      pos_in = pos_ff;
      if (push) begin
         pos_in = boundary ? LEN_W'(1) : pos_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ----- rtl/tdlc_queue.sv -----
// ----------------------------------------------------------------------------
// tdlc_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module tdlc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  tdlc_pkg::tdlc_qent_type  push_data,
   input  logic                     pop,
   output logic                     full,
   output logic                     empty,
   output tdlc_pkg::tdlc_qent_type  head
);
   import tdlc_pkg::*;

   tdlc_qent_type ent_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/tdlc_back.sv -----
// ----------------------------------------------------------------------------
// tdlc_back
// Walks the dirty set one entry a cycle, updates counters, issues results.
// ----------------------------------------------------------------------------
module tdlc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  tdlc_pkg::tdlc_qent_type  q_head,
   output logic                     pop,
   output logic                     rsp_valid,
   output tdlc_pkg::tdlc_rsp_type   rsp_data
);
   import tdlc_pkg::*;

   localparam logic S_IDLE   = 1'b0;
   localparam logic S_SEARCH = 1'b1;

   logic [ADDRESS_BITS-1:0] mem [SET_CAPACITY];

   logic                    state_ff, state_in;
   logic                    kind_ff, kind_in;
   logic [ADDRESS_BITS-1:0] addr_ff, addr_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic [FILL_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic [ADDRESS_BITS-1:0] rd_data_ff;
   logic [CNT_W-1:0]        txn_ff, txn_in;
   logic [CNT_W-1:0]        flush_ff, flush_in;
   logic [CNT_W-1:0]        reads_ff, reads_in;
   logic [CNT_W-1:0]        writes_ff, writes_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   tdlc_rsp_type            rsp_ff, rsp_in;

   logic issue;
   logic hit;
   logic finish;
   logic room;
   logic store;

   assign pop    = (state_ff == S_IDLE) & ~q_empty;
   assign issue  = (state_ff == S_SEARCH) & kind_ff & (rd_idx_ff < fill_ff);
   assign hit    = cmp_vld_ff & (rd_data_ff == addr_ff);
   // reads finish at once; writes once matched or every entry compared
   assign finish = (state_ff == S_SEARCH) & (~kind_ff | hit | ~issue);
   assign room   = (fill_ff < FILL_W'(SET_CAPACITY));
   assign store  = finish & kind_ff & ~hit & room;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      addr_in      = addr_ff;
      fill_in      = fill_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_vld_in   = 1'b0;
      txn_in       = txn_ff;
      flush_in     = flush_ff;
      reads_in     = reads_ff;
      writes_in    = writes_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               state_in  = S_SEARCH;
               kind_in   = q_head.kind;
               addr_in   = q_head.line_address;
               rd_idx_in = '0;
               if (q_head.new_txn) begin
                  fill_in = '0;
                  txn_in  = sat_inc(txn_ff);
               end
            end
         end
         S_SEARCH: begin
            cmp_vld_in = issue;
            if (issue) begin
               rd_idx_in = rd_idx_ff + FILL_W'(1);
            end
            if (finish) begin
               state_in = S_IDLE;
               if (kind_ff) begin
                  writes_in = sat_inc(writes_ff);
                  if (store) begin
                     fill_in  = fill_ff + FILL_W'(1);
                     flush_in = sat_inc(flush_ff);
                  end
               end else begin
                  reads_in = sat_inc(reads_ff);
               end
               rsp_valid_in             = 1'b1;
               rsp_in.transaction_index = txn_ff;
               rsp_in.flush_count       = flush_in;
               rsp_in.read_count        = reads_in;
               rsp_in.write_count       = writes_in;
               rsp_in.newly_dirtied     = store;
               rsp_in.set_full          = kind_ff & ~hit & ~room;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // dirty-set storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (store) begin
         mem[fill_ff[IDX_W-1:0]] <= addr_ff;
      end
      if (issue) begin
         rd_data_ff <= mem[rd_idx_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      addr_ff <= addr_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rd_idx_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         txn_ff       <= '0;
         flush_ff     <= '0;
         reads_ff     <= '0;
         writes_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         txn_ff       <= txn_in;
         flush_ff     <= flush_in;
         reads_ff     <= reads_in;
         writes_ff    <= writes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/tdlc_checker.sv -----
// ----------------------------------------------------------------------------
// tdlc_checker
// Port-level checks on the dirty-line counter, bound to the top level.
// ----------------------------------------------------------------------------
module tdlc_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              busy,
   input  logic                              rsp_valid,
   input  tdlc_pkg::tdlc_rsp_type            rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [tdlc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [tdlc_pkg::CSR_DATA_W-1:0]   pwdata,
   input  logic [tdlc_pkg::CSR_DATA_W-1:0]   prdata,
   input  logic                              pready
);
   import tdlc_pkg::*;

   // after reset nothing is queued and nothing is in flight
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("busy or result right after reset");

   // the back end passes through idle between items, so results never come back to back
   a_result_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results on consecutive cycles");

   // a flag implies a write was counted, and never both flags at once
   a_flag_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.newly_dirtied || rsp_data.set_full)) |->
      (rsp_data.write_count != '0 &&
       !(rsp_data.newly_dirtied && rsp_data.set_full)))
      else $error("dirty flags inconsistent with write count");

   // a length write reads back on the next cycle
   a_len_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && pready &&
       paddr[CSR_ADDR_W-1:2] == REG_TRANSACTION_LENGTH) |=>
      (paddr[CSR_ADDR_W-1:2] != REG_TRANSACTION_LENGTH ||
       prdata[LEN_W-1:0] == $past(pwdata[LEN_W-1:0])))
      else $error("transaction length did not read back");

endmodule

bind transaction_dirty_line_counter_unit tdlc_checker u_tdlc_checker (.*);
